// ===== hdl/i2chc_pkg.sv =====
// Package of shared types, address map and codes for the I2C host controller register block.
`default_nettype none

package i2chc_pkg;

    // Channel and device slot counts.
    localparam int MAX_CHANNELS     = 3;
    localparam int DEF_NUM_CHANNELS = 3;
    localparam int SLOT_COUNT       = 3;
    localparam int MAX_DEVICES      = 3;
    localparam int SEARCH_SLOTS     = (MAX_DEVICES < SLOT_COUNT) ? MAX_DEVICES : SLOT_COUNT;

    // Field widths.
    localparam int DATA_W   = 32;
    localparam int OFF_W    = 10;
    localparam int WIN_W    = DATA_W - OFF_W;
    localparam int DEV_W    = 7;
    localparam int CHAN_W   = 2;
    localparam int SLOT_W   = 2;
    localparam int PRES_W   = 3;
    localparam int EN_W     = 5;
    localparam int STAT_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int EVENT_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;

    // Address map.
    localparam logic [DATA_W-1:0] CHAN_BASE  = 32'hF000_6000;
    localparam logic [WIN_W-1:0]  WIN_BASE   = CHAN_BASE[DATA_W-1:OFF_W];
    localparam logic [DATA_W-1:0] G_IRQ_ADDR = 32'hF000_5800;
    localparam logic [DATA_W-1:0] G_EN_ADDR  = 32'hF000_5804;
    localparam logic [DATA_W-1:0] G_CLR_ADDR = 32'hF000_5808;

    // Offsets inside a channel window.
    localparam logic [OFF_W-1:0] OFF_SCRATCH_ZERO   = 10'h000;
    localparam logic [OFF_W-1:0] OFF_DATA           = 10'h004;
    localparam logic [OFF_W-1:0] OFF_CONTROL        = 10'h008;
    localparam logic [OFF_W-1:0] OFF_SCRATCH_TEN    = 10'h010;
    localparam logic [OFF_W-1:0] OFF_STATUS         = 10'h018;
    localparam logic [OFF_W-1:0] OFF_SCRATCH_TWENTY = 10'h020;

    // Control register bit positions.
    localparam int CTRL_STOP   = 0;
    localparam int CTRL_START  = 1;
    localparam int CTRL_RD_EN  = 2;
    localparam int CTRL_RD_REQ = 5;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_IDLE       = 4'h0;
    localparam logic [STAT_W-1:0] ST_STOPPED    = 4'h1;
    localparam logic [STAT_W-1:0] ST_ADDR_NACK  = 4'h2;
    localparam logic [STAT_W-1:0] ST_ADDR_ACK   = 4'h6;
    localparam logic [STAT_W-1:0] ST_WRITE_MODE = 4'h8;
    localparam logic [STAT_W-1:0] ST_TX_ACK     = 4'hC;

    // Device event codes.
    localparam logic [EVENT_W-1:0] EV_NONE  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_START = 3'd1;
    localparam logic [EVENT_W-1:0] EV_STOP  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_READ  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_WRITE = 3'd4;

    // Bus command codes.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [SLOT_W-1:0] NO_SLOT   = 2'd3;
    localparam logic [BYTE_W-1:0] NO_DEVICE_BYTE = 8'hFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_C  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_A  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_B  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_C  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 3'd6;

    // Configuration reset values.
    localparam logic [DEV_W-1:0]  RST_ADDR_A  = 7'h18;
    localparam logic [DEV_W-1:0]  RST_ADDR_B  = 7'h21;
    localparam logic [DEV_W-1:0]  RST_ADDR_C  = 7'h39;
    localparam logic [CHAN_W-1:0] RST_CHAN    = 2'd1;
    localparam logic [PRES_W-1:0] RST_PRESENT = 3'd7;

    // One bus access.
    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] address;
        logic [DATA_W-1:0] write_value;
        logic [BYTE_W-1:0] device_byte;
    } in_item_t;

    // One access result.
    typedef struct packed {
        logic [DATA_W-1:0]  read_value;
        logic [EVENT_W-1:0] device_event;
        logic [SLOT_W-1:0]  event_slot;
        logic [BYTE_W-1:0]  event_byte;
        logic               irq_raise;
    } out_item_t;

    // Attached device slot configuration.
    typedef struct packed {
        logic [SLOT_COUNT-1:0][DEV_W-1:0]  addr;
        logic [SLOT_COUNT-1:0][CHAN_W-1:0] chan;
        logic [PRES_W-1:0]                 present;
    } dev_cfg_t;

    // Response of one channel register file to the current access.
    typedef struct packed {
        logic [DATA_W-1:0]  rdata;
        logic [EVENT_W-1:0] event_kind;
        logic [SLOT_W-1:0]  event_slot;
        logic [BYTE_W-1:0]  event_byte;
        logic               irq;
    } chan_resp_t;

endpackage

`default_nettype wire

// ===== hdl/i2chc_channel.sv =====
// Register file and bus actions of one I2C host channel.
`default_nettype none

module i2chc_channel (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  update,
    input  wire i2chc_pkg::in_item_t   item,
    input  wire logic [1:0]            chan_id,
    input  wire logic                  enabled,
    input  wire i2chc_pkg::dev_cfg_t   dev_cfg,
    output i2chc_pkg::chan_resp_t      resp
);
    import i2chc_pkg::*;

    logic [DATA_W-1:0] control_reg, control_next;
    logic [DATA_W-1:0] scratch_zero_reg, scratch_zero_next;
    logic [DATA_W-1:0] scratch_ten_reg, scratch_ten_next;
    logic [DATA_W-1:0] scratch_twenty_reg, scratch_twenty_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0] read_byte_reg, read_byte_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [OFF_W-1:0]  offset;
    logic [DATA_W-1:0] wval;
    logic [BYTE_W-1:0] wbyte;
    logic [SLOT_W-1:0] match_slot;

    assign offset = item.address[OFF_W-1:0];
    assign wval   = item.write_value;
    assign wbyte  = item.write_value[BYTE_W-1:0];

    // Lowest populated slot on this channel whose address matches the start byte.
    always_comb
    begin
        match_slot = NO_SLOT;
        for (int i = SEARCH_SLOTS - 1; i >= 0; i--)
        begin
            if (dev_cfg.present[i] && (dev_cfg.chan[i] == chan_id) &&
                (dev_cfg.addr[i] == wbyte[BYTE_W-1:1]))
            begin
                match_slot = SLOT_W'(i);
            end
        end
    end

    // Read mux and write actions for the current access.
    always_comb
    begin
        control_next        = control_reg;
        scratch_zero_next   = scratch_zero_reg;
        scratch_ten_next    = scratch_ten_reg;
        scratch_twenty_next = scratch_twenty_reg;
        status_next         = status_reg;
        read_byte_next      = read_byte_reg;
        slot_next           = slot_reg;
        resp                = '0;

        if (item.command == CMD_READ)
        begin
            case (offset)
                OFF_SCRATCH_ZERO:   resp.rdata = scratch_zero_reg;
                OFF_DATA:           resp.rdata = DATA_W'(read_byte_reg);
                OFF_CONTROL:        resp.rdata = control_reg;
                OFF_SCRATCH_TEN:    resp.rdata = scratch_ten_reg;
                OFF_STATUS:         resp.rdata = DATA_W'(status_reg);
                OFF_SCRATCH_TWENTY: resp.rdata = scratch_twenty_reg;
                default:            resp.rdata = '0;
            endcase
        end
        else
        begin
            case (offset)
                OFF_SCRATCH_ZERO:   scratch_zero_next = wval;
                OFF_SCRATCH_TEN:    scratch_ten_next = wval;
                OFF_SCRATCH_TWENTY: scratch_twenty_next = wval;
                OFF_DATA:
                begin
                    // Data writes on a disabled channel are dropped entirely.
                    if (enabled)
                    begin
                        resp.irq = 1'b1;
                        if (control_reg[CTRL_START])
                        begin
                            // Address phase: select the matching device.
                            slot_next = match_slot;
                            if (match_slot != NO_SLOT)
                            begin
                                resp.event_kind = EV_START;
                                resp.event_slot = match_slot;
                                status_next     = ST_ADDR_ACK;
                            end
                            else
                            begin
                                status_next = ST_ADDR_NACK;
                            end
                            if (!wbyte[0])
                            begin
                                status_next = status_next | ST_WRITE_MODE;
                            end
                            control_next = control_reg;
                            control_next[CTRL_START] = 1'b0;
                        end
                        else if (slot_reg != NO_SLOT)
                        begin
                            resp.event_kind = EV_WRITE;
                            resp.event_slot = slot_reg;
                            resp.event_byte = wbyte;
                            status_next     = ST_TX_ACK;
                        end
                        else
                        begin
                            status_next = ST_WRITE_MODE;
                        end
                    end
                end
                OFF_CONTROL:
                begin
                    control_next = wval;
                    if (wval[CTRL_STOP])
                    begin
                        // Stop wins over a read request in the same write.
                        if (slot_reg != NO_SLOT)
                        begin
                            resp.event_kind = EV_STOP;
                            resp.event_slot = slot_reg;
                            slot_next       = NO_SLOT;
                        end
                        status_next = ST_STOPPED;
                        resp.irq    = 1'b1;
                        control_next[CTRL_STOP] = 1'b0;
                    end
                    else if (wval[CTRL_RD_REQ])
                    begin
                        if (wval[CTRL_RD_EN])
                        begin
                            if (slot_reg != NO_SLOT)
                            begin
                                resp.event_kind = EV_READ;
                                resp.event_slot = slot_reg;
                                read_byte_next  = item.device_byte;
                            end
                            else
                            begin
                                read_byte_next = NO_DEVICE_BYTE;
                            end
                        end
                        status_next = ST_IDLE;
                        resp.irq    = 1'b1;
                        control_next[CTRL_RD_REQ] = 1'b0;
                    end
                end
                default:
                begin
                    // Status and unmapped offsets ignore writes.
                end
            endcase
        end
    end

    // Channel state, committed when the access leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg        <= '0;
            scratch_zero_reg   <= '0;
            scratch_ten_reg    <= '0;
            scratch_twenty_reg <= '0;
            status_reg         <= ST_IDLE;
            read_byte_reg      <= '0;
            slot_reg           <= NO_SLOT;
        end
        else if (update)
        begin
            control_reg        <= control_next;
            scratch_zero_reg   <= scratch_zero_next;
            scratch_ten_reg    <= scratch_ten_next;
            scratch_twenty_reg <= scratch_twenty_next;
            status_reg         <= status_next;
            read_byte_reg      <= read_byte_next;
            slot_reg           <= slot_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/i2c_host_controller_regs.sv =====
// Top level of the I2C host controller register block.
//
// The block is a bus slave: each transfer on the input channel is one read or
// write access, and each access yields exactly one result transfer carrying the
// read data, a device event (start, stop, read byte, write byte) and an IRQ flag.
// Both channels use valid/ready. An access is captured in an input register,
// decoded and applied to the register state in one short pass, and the result
// is then registered in an output register. While the receiver does not stall,
// a new access is taken every cycle, so throughput is one access per clock, set
// by the single state update pass from input to output register.
// When the receiver stalls, the output register holds its result and the input
// register holds one more access; only then does ready drop.
// The device slot configuration is written through cfg_write/cfg_index/cfg_data
// and takes effect for accesses after the write.
// Reset clears all channel registers, the enable and IRQ registers, deselects
// every channel and restores the default device slot configuration.
`default_nettype none

module i2c_host_controller_regs #(
    parameter int NUM_CHANNELS = i2chc_pkg::DEF_NUM_CHANNELS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire i2chc_pkg::in_item_t                in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output i2chc_pkg::out_item_t                    out_data,
    input  wire logic                               cfg_write,
    input  wire logic [i2chc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [i2chc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import i2chc_pkg::*;

    logic      s0_valid_reg;
    in_item_t  s0_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t result;
    logic      advance;

    dev_cfg_t          dev_cfg_reg;
    logic [EN_W-1:0]   enable_reg, enable_next;
    logic [EN_W-1:0]   irq_reg, irq_next;
    logic [EN_W-1:0]   irq_set;

    logic [NUM_CHANNELS-1:0] chan_hit;
    chan_resp_t              chan_resp [NUM_CHANNELS];

    // Pipeline handshake: the input register drains whenever the output is free.
    assign advance   = s0_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s0_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Channel windows and their register files.
    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_chan
        assign chan_hit[c] = (s0_item_reg.address[DATA_W-1:OFF_W] == WIN_BASE + WIN_W'(c));

        i2chc_channel u_chan (
            .clk     (clk),
            .rst_n   (rst_n),
            .update  (advance && chan_hit[c]),
            .item    (s0_item_reg),
            .chan_id (CHAN_W'(c)),
            .enabled (enable_reg[c + 2]),
            .dev_cfg (dev_cfg_reg),
            .resp    (chan_resp[c])
        );
    end

    // Result assembly and global register decode.
    always_comb
    begin
        result      = '0;
        irq_set     = '0;
        enable_next = enable_reg;
        irq_next    = irq_reg;

        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (chan_hit[c])
            begin
                result.read_value   = chan_resp[c].rdata;
                result.device_event = chan_resp[c].event_kind;
                result.event_slot   = chan_resp[c].event_slot;
                result.event_byte   = chan_resp[c].event_byte;
                result.irq_raise    = chan_resp[c].irq;
                irq_set[c + 2]      = chan_resp[c].irq;
            end
        end

        if (!(|chan_hit))
        begin
            if (s0_item_reg.command == CMD_READ)
            begin
                if (s0_item_reg.address == G_IRQ_ADDR)
                begin
                    result.read_value = DATA_W'(irq_reg);
                end
                else if (s0_item_reg.address == G_EN_ADDR)
                begin
                    result.read_value = DATA_W'(enable_reg);
                end
            end
            else
            begin
                if (s0_item_reg.address == G_EN_ADDR)
                begin
                    enable_next = s0_item_reg.write_value[EN_W-1:0];
                end
                else if (s0_item_reg.address == G_CLR_ADDR)
                begin
                    irq_next = irq_reg & ~s0_item_reg.write_value[EN_W-1:0];
                end
            end
        end

        irq_next = irq_next | irq_set;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s0_item_reg <= in_data;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    // Global enable and IRQ registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            irq_reg    <= '0;
        end
        else if (advance)
        begin
            enable_reg <= enable_next;
            irq_reg    <= irq_next;
        end
    end

    // Device slot configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_cfg_reg.addr[0] <= RST_ADDR_A;
            dev_cfg_reg.addr[1] <= RST_ADDR_B;
            dev_cfg_reg.addr[2] <= RST_ADDR_C;
            dev_cfg_reg.chan[0] <= RST_CHAN;
            dev_cfg_reg.chan[1] <= RST_CHAN;
            dev_cfg_reg.chan[2] <= RST_CHAN;
            dev_cfg_reg.present <= RST_PRESENT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ADDR_A:  dev_cfg_reg.addr[0] <= cfg_data[DEV_W-1:0];
                CFG_ADDR_B:  dev_cfg_reg.addr[1] <= cfg_data[DEV_W-1:0];
                CFG_ADDR_C:  dev_cfg_reg.addr[2] <= cfg_data[DEV_W-1:0];
                CFG_CHAN_A:  dev_cfg_reg.chan[0] <= cfg_data[CHAN_W-1:0];
                CFG_CHAN_B:  dev_cfg_reg.chan[1] <= cfg_data[CHAN_W-1:0];
                CFG_CHAN_C:  dev_cfg_reg.chan[2] <= cfg_data[CHAN_W-1:0];
                CFG_PRESENT: dev_cfg_reg.present <= cfg_data[PRES_W-1:0];
                default:
                begin
                    // Indexes beyond the list are ignored.
                end
            endcase
        end
    end

    // Every device event is reported together with a channel IRQ.
    a_event_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.device_event != EV_NONE)) |-> out_data.irq_raise)
        else $error("device event without IRQ");

    // IRQs come only from writes, which return zero read data.
    a_irq_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.irq_raise) |-> (out_data.read_value == '0))
        else $error("IRQ raised with nonzero read data");

    // The two low IRQ bits belong to no channel and never get set.
    a_irq_low: assert property (@(posedge clk) disable iff (!rst_n)
        irq_reg[1:0] == 2'b00)
        else $error("IRQ bit outside channel range set");

    // Input stalls only when both pipeline registers are full and blocked.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s0_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== tb/sv/tb_i2c_host_controller_regs.sv =====
// Self-checking testbench of the I2C host controller register block with its own register predictor.
module tb_i2c_host_controller_regs;

    import i2chc_pkg::*;

    // One row of the directed stimulus: the access and, where pinned, its result.
    typedef struct {
        in_item_t  acc;
        bit        pinned;
        out_item_t res;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted register state and device slot configuration.
    logic [DEV_W-1:0]  slot_addr_m [SLOT_COUNT];
    logic [CHAN_W-1:0] slot_chan_m [SLOT_COUNT];
    logic [PRES_W-1:0] slot_present_m;
    logic [EN_W-1:0]   enable_m;
    logic [EN_W-1:0]   irq_m;
    logic [DATA_W-1:0] control_m   [MAX_CHANNELS];
    logic [STAT_W-1:0] status_m    [MAX_CHANNELS];
    logic [BYTE_W-1:0] rx_byte_m   [MAX_CHANNELS];
    logic [SLOT_W-1:0] selected_m  [MAX_CHANNELS];
    logic [DATA_W-1:0] scratch0_m  [MAX_CHANNELS];
    logic [DATA_W-1:0] scratch10_m [MAX_CHANNELS];
    logic [DATA_W-1:0] scratch20_m [MAX_CHANNELS];

    out_item_t pending_results [$];
    dir_row_t  directed [$];
    int        error_count;
    int        sent_count;
    int        src_gap_pct;
    int        sink_stall_pct;
    bit        no_idle;

    i2c_host_controller_regs i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a period of 20 time units.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Address of a register inside a channel window.
    function automatic logic [DATA_W-1:0] chan_reg(input int ch, input logic [OFF_W-1:0] off);
        return {WIN_BASE + WIN_W'(ch), off};
    endfunction

    // One of the mapped offsets of a channel window.
    function automatic logic [OFF_W-1:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return OFF_SCRATCH_ZERO;
            1: return OFF_DATA;
            2: return OFF_CONTROL;
            3: return OFF_SCRATCH_TEN;
            4: return OFF_STATUS;
            default: return OFF_SCRATCH_TWENTY;
        endcase
    endfunction

    // Bus access with a random device byte.
    function automatic in_item_t mk_access(input logic cmd, input logic [DATA_W-1:0] addr,
                                           input logic [DATA_W-1:0] val);
        in_item_t a;
        a.command     = cmd;
        a.address     = addr;
        a.write_value = val;
        a.device_byte = BYTE_W'($urandom);
        return a;
    endfunction

    function automatic dir_row_t row(input logic cmd, input logic [DATA_W-1:0] addr,
                                     input logic [DATA_W-1:0] val, input logic [BYTE_W-1:0] dbyte,
                                     input bit pinned, input logic [DATA_W-1:0] rv,
                                     input logic [EVENT_W-1:0] ev, input logic [SLOT_W-1:0] slot,
                                     input logic [BYTE_W-1:0] eb, input logic irq);
        dir_row_t r;
        r.acc.command      = cmd;
        r.acc.address      = addr;
        r.acc.write_value  = val;
        r.acc.device_byte  = dbyte;
        r.pinned           = pinned;
        r.res.read_value   = rv;
        r.res.device_event = ev;
        r.res.event_slot   = slot;
        r.res.event_byte   = eb;
        r.res.irq_raise    = irq;
        return r;
    endfunction

    // Applies one access to the predicted state and returns the result it gives.
    function automatic out_item_t predict_access(input in_item_t a);
        out_item_t         r;
        int                ch;
        logic [DATA_W-1:0] v;
        logic [BYTE_W-1:0] b;
        r  = '0;
        ch = -1;
        v  = a.write_value;
        b  = v[BYTE_W-1:0];
        for (int c = 0; c < DEF_NUM_CHANNELS; c++)
        begin
            if (a.address[DATA_W-1:OFF_W] == WIN_BASE + WIN_W'(c))
                ch = c;
        end
        if (ch >= 0)
        begin
            if (a.command == CMD_READ)
            begin
                case (a.address[OFF_W-1:0])
                    OFF_SCRATCH_ZERO:   r.read_value = scratch0_m[ch];
                    OFF_DATA:           r.read_value = DATA_W'(rx_byte_m[ch]);
                    OFF_CONTROL:        r.read_value = control_m[ch];
                    OFF_SCRATCH_TEN:    r.read_value = scratch10_m[ch];
                    OFF_STATUS:         r.read_value = DATA_W'(status_m[ch]);
                    OFF_SCRATCH_TWENTY: r.read_value = scratch20_m[ch];
                    default:            r.read_value = '0;
                endcase
            end
            else
            begin
                case (a.address[OFF_W-1:0])
                    OFF_SCRATCH_ZERO:   scratch0_m[ch] = v;
                    OFF_SCRATCH_TEN:    scratch10_m[ch] = v;
                    OFF_SCRATCH_TWENTY: scratch20_m[ch] = v;
                    OFF_CONTROL:
                    begin
                        control_m[ch] = v;
                        if (v[CTRL_STOP])
                        begin
                            // Stop wins over a read request issued with it.
                            if (selected_m[ch] != NO_SLOT)
                            begin
                                r.device_event = EV_STOP;
                                r.event_slot   = selected_m[ch];
                                selected_m[ch] = NO_SLOT;
                            end
                            status_m[ch]             = ST_STOPPED;
                            irq_m[ch+2]              = 1'b1;
                            r.irq_raise              = 1'b1;
                            control_m[ch][CTRL_STOP] = 1'b0;
                        end
                        else if (v[CTRL_RD_REQ])
                        begin
                            if (v[CTRL_RD_EN])
                            begin
                                if (selected_m[ch] != NO_SLOT)
                                begin
                                    r.device_event = EV_READ;
                                    r.event_slot   = selected_m[ch];
                                    rx_byte_m[ch]  = a.device_byte;
                                end
                                else
                                    rx_byte_m[ch] = NO_DEVICE_BYTE;
                            end
                            status_m[ch]               = ST_IDLE;
                            irq_m[ch+2]                = 1'b1;
                            r.irq_raise                = 1'b1;
                            control_m[ch][CTRL_RD_REQ] = 1'b0;
                        end
                    end
                    OFF_DATA:
                    begin
                        // A data write on a disabled channel leaves everything alone.
                        if (enable_m[ch+2])
                        begin
                            if (control_m[ch][CTRL_START])
                            begin
                                selected_m[ch] = NO_SLOT;
                                for (int i = 0; i < SEARCH_SLOTS; i++)
                                begin
                                    if (selected_m[ch] == NO_SLOT && slot_present_m[i] &&
                                        slot_chan_m[i] == CHAN_W'(ch) &&
                                        slot_addr_m[i] == b[BYTE_W-1:1])
                                        selected_m[ch] = SLOT_W'(i);
                                end
                                if (selected_m[ch] != NO_SLOT)
                                begin
                                    r.device_event = EV_START;
                                    r.event_slot   = selected_m[ch];
                                    status_m[ch]   = ST_ADDR_ACK;
                                end
                                else
                                    status_m[ch] = ST_ADDR_NACK;
                                if (!b[0])
                                    status_m[ch] = status_m[ch] | ST_WRITE_MODE;
                                control_m[ch][CTRL_START] = 1'b0;
                            end
                            else if (selected_m[ch] != NO_SLOT)
                            begin
                                r.device_event = EV_WRITE;
                                r.event_slot   = selected_m[ch];
                                r.event_byte   = b;
                                status_m[ch]   = ST_TX_ACK;
                            end
                            else
                                status_m[ch] = ST_WRITE_MODE;
                            irq_m[ch+2] = 1'b1;
                            r.irq_raise = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        else if (a.command == CMD_READ)
        begin
            if (a.address == G_IRQ_ADDR)
                r.read_value = DATA_W'(irq_m);
            else if (a.address == G_EN_ADDR)
                r.read_value = DATA_W'(enable_m);
        end
        else
        begin
            if (a.address == G_EN_ADDR)
                enable_m = v[EN_W-1:0];
            else if (a.address == G_CLR_ADDR)
                irq_m = irq_m & ~v[EN_W-1:0];
        end
        return r;
    endfunction

    // Offers one access, waits for its transfer and records what it should give.
    task automatic send_access(input in_item_t a, input bit pinned = 1'b0,
                               input out_item_t pinned_res = '0);
        out_item_t p;
        if (!no_idle && $urandom_range(0, 99) < src_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_data  <= a;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = predict_access(a);
        pending_results.push_back(pinned ? pinned_res : p);
        sent_count++;
    endtask

    // Lets every outstanding result arrive, plus the pipeline latency.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // One configuration write; the caller lowers the enable after a group of writes.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_ADDR_A:  slot_addr_m[0] = val;
            CFG_ADDR_B:  slot_addr_m[1] = val;
            CFG_ADDR_C:  slot_addr_m[2] = val;
            CFG_CHAN_A:  slot_chan_m[0] = val[CHAN_W-1:0];
            CFG_CHAN_B:  slot_chan_m[1] = val[CHAN_W-1:0];
            CFG_CHAN_C:  slot_chan_m[2] = val[CHAN_W-1:0];
            CFG_PRESENT: slot_present_m = val[PRES_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_devices(input logic [CFG_DATA_W-1:0] a0, a1, a2, c0, c1, c2, pres);
        write_cfg(CFG_ADDR_A, a0);
        write_cfg(CFG_ADDR_B, a1);
        write_cfg(CFG_ADDR_C, a2);
        write_cfg(CFG_CHAN_A, c0);
        write_cfg(CFG_CHAN_B, c1);
        write_cfg(CFG_CHAN_C, c2);
        write_cfg(CFG_PRESENT, pres);
        cfg_write <= 1'b0;
    endtask

    // A bus transaction: start with an address byte, some traffic, then mostly a stop.
    task automatic run_bus_sequence();
        int                ch;
        int                slot;
        logic [DATA_W-1:0] v;
        logic [BYTE_W-1:0] abyte;
        ch = $urandom_range(0, DEF_NUM_CHANNELS - 1);
        if ($urandom_range(0, 3) == 0)
        begin
            v = $urandom;
            if ($urandom_range(0, 7) != 0)
                v[ch+2] = 1'b1;
            send_access(mk_access(CMD_WRITE, G_EN_ADDR, v));
        end
        v = $urandom;
        v[CTRL_STOP]   = 1'b0;
        v[CTRL_RD_REQ] = 1'b0;
        v[CTRL_START]  = 1'b1;
        send_access(mk_access(CMD_WRITE, chan_reg(ch, OFF_CONTROL), v));
        slot  = $urandom_range(0, SLOT_COUNT - 1);
        abyte = BYTE_W'($urandom);
        if ($urandom_range(0, 3) != 0)
            abyte[BYTE_W-1:1] = slot_addr_m[slot];
        v = $urandom;
        v[BYTE_W-1:0] = abyte;
        send_access(mk_access(CMD_WRITE, chan_reg(ch, OFF_DATA), v));
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 3))
                0, 1: send_access(mk_access(CMD_WRITE, chan_reg(ch, OFF_DATA), $urandom));
                2:
                begin
                    v = $urandom;
                    v[CTRL_STOP]   = 1'b0;
                    v[CTRL_RD_REQ] = 1'b1;
                    v[CTRL_RD_EN]  = ($urandom_range(0, 3) != 0);
                    send_access(mk_access(CMD_WRITE, chan_reg(ch, OFF_CONTROL), v));
                end
                default: send_access(mk_access(CMD_READ, chan_reg(ch, pick_offset()), $urandom));
            endcase
        end
        if ($urandom_range(0, 5) != 0)
        begin
            v = $urandom;
            v[CTRL_STOP] = 1'b1;
            send_access(mk_access(CMD_WRITE, chan_reg(ch, OFF_CONTROL), v));
        end
    endtask

    // A loose access anywhere in or near the address map.
    task automatic send_loose_access();
        logic [DATA_W-1:0] addr;
        logic              cmd;
        cmd = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: addr = $urandom;
            1: addr = chan_reg($urandom_range(0, MAX_CHANNELS), OFF_W'($urandom));
            2: addr = chan_reg($urandom_range(0, DEF_NUM_CHANNELS - 1), pick_offset());
            3:
            begin
                case ($urandom_range(0, 2))
                    0: addr = G_IRQ_ADDR;
                    1: addr = G_EN_ADDR;
                    default: addr = G_CLR_ADDR;
                endcase
            end
            4: addr = G_IRQ_ADDR ^ (DATA_W'(1) << $urandom_range(0, DATA_W - 1));
            default:
            begin
                addr = chan_reg($urandom_range(0, DEF_NUM_CHANNELS - 1), pick_offset());
                cmd  = CMD_READ;
            end
        endcase
        send_access(mk_access(cmd, addr, $urandom));
    endtask

    // Receiver stalls in random bursts.
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!no_idle && $urandom_range(0, 99) < sink_stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest expected result.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no access outstanding: %h", out_data);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.read_value !== want.read_value)
                begin
                    $error("read_value: expected %h, actual %h", want.read_value,
                           out_data.read_value);
                    error_count++;
                end
                if (out_data.device_event !== want.device_event)
                begin
                    $error("device_event: expected %0d, actual %0d", want.device_event,
                           out_data.device_event);
                    error_count++;
                end
                if (out_data.event_slot !== want.event_slot)
                begin
                    $error("event_slot: expected %0d, actual %0d", want.event_slot,
                           out_data.event_slot);
                    error_count++;
                end
                if (out_data.event_byte !== want.event_byte)
                begin
                    $error("event_byte: expected %h, actual %h", want.event_byte,
                           out_data.event_byte);
                    error_count++;
                end
                if (out_data.irq_raise !== want.irq_raise)
                begin
                    $error("irq_raise: expected %b, actual %b", want.irq_raise,
                           out_data.irq_raise);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        #6000000;
        $display("[i2c_host_controller_regs] ERROR");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        int target;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        error_count    = 0;
        sent_count     = 0;
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        no_idle        = 1'b0;

        // Predicted state after reset.
        slot_addr_m[0] = RST_ADDR_A;
        slot_addr_m[1] = RST_ADDR_B;
        slot_addr_m[2] = RST_ADDR_C;
        for (int i = 0; i < SLOT_COUNT; i++)
            slot_chan_m[i] = RST_CHAN;
        slot_present_m = RST_PRESENT;
        enable_m       = '0;
        irq_m          = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            control_m[c]   = '0;
            status_m[c]    = '0;
            rx_byte_m[c]   = '0;
            selected_m[c]  = NO_SLOT;
            scratch0_m[c]  = '0;
            scratch10_m[c] = '0;
            scratch20_m[c] = '0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset device configuration (all slots on channel one).
        directed.push_back(row(CMD_READ, G_IRQ_ADDR, '0, 8'h00,
                               1, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_READ, G_EN_ADDR, '0, 8'h00,
                               1, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        // Data write while the channel is disabled.
        directed.push_back(row(CMD_WRITE, chan_reg(1, OFF_DATA), 32'hFF, 8'hFF,
                               1, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_WRITE, G_EN_ADDR, 32'hFFFF_FFFF, 8'h00,
                               1, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_READ, G_EN_ADDR, '0, 8'h00,
                               1, 32'h1F, EV_NONE, 2'd0, 8'h00, 1'b0));
        // Status is read only.
        directed.push_back(row(CMD_WRITE, chan_reg(1, OFF_STATUS), 32'hFFFF_FFFF, 8'h00,
                               1, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        // Byte write with no device selected.
        directed.push_back(row(CMD_WRITE, chan_reg(1, OFF_DATA), 32'h1234_5600, 8'h00,
                               1, '0, EV_NONE, 2'd0, 8'h00, 1'b1));
        directed.push_back(row(CMD_READ, chan_reg(1, OFF_STATUS), '0, 8'h00,
                               1, DATA_W'(ST_WRITE_MODE), EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_WRITE, chan_reg(1, OFF_CONTROL), 32'h2, 8'h00,
                               1, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_WRITE, chan_reg(1, OFF_DATA), {24'hFF_FFFF, RST_ADDR_A, 1'b0},
                               8'h00, 1, '0, EV_START, 2'd0, 8'h00, 1'b1));
        directed.push_back(row(CMD_READ, chan_reg(1, OFF_STATUS), '0, 8'h00,
                               0, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_WRITE, chan_reg(1, OFF_DATA), 32'hA5, 8'h00,
                               1, '0, EV_WRITE, 2'd0, 8'hA5, 1'b1));
        directed.push_back(row(CMD_WRITE, chan_reg(1, OFF_CONTROL), 32'h24, 8'h5A,
                               1, '0, EV_READ, 2'd0, 8'h00, 1'b1));
        directed.push_back(row(CMD_READ, chan_reg(1, OFF_DATA), '0, 8'h00,
                               1, 32'h5A, EV_NONE, 2'd0, 8'h00, 1'b0));
        // Stop together with a read request: stop wins, the request bit stays.
        directed.push_back(row(CMD_WRITE, chan_reg(1, OFF_CONTROL), 32'h21, 8'h00,
                               1, '0, EV_STOP, 2'd0, 8'h00, 1'b1));
        directed.push_back(row(CMD_READ, chan_reg(1, OFF_CONTROL), '0, 8'h00,
                               1, 32'h20, EV_NONE, 2'd0, 8'h00, 1'b0));
        // Read request with no device selected.
        directed.push_back(row(CMD_WRITE, chan_reg(1, OFF_CONTROL), 32'h24, 8'h33,
                               0, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_READ, chan_reg(1, OFF_DATA), '0, 8'h00,
                               1, DATA_W'(NO_DEVICE_BYTE), EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_WRITE, chan_reg(1, OFF_CONTROL), 32'hFFFF_FFFE, 8'h00,
                               0, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_WRITE, chan_reg(1, OFF_DATA), {24'h0, RST_ADDR_B, 1'b1},
                               8'h00, 0, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        // Read request without the read enable bit keeps the received byte.
        directed.push_back(row(CMD_WRITE, chan_reg(1, OFF_CONTROL), 32'h20, 8'h77,
                               0, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_READ, chan_reg(1, OFF_DATA), '0, 8'h00,
                               0, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_WRITE, G_CLR_ADDR, 32'hFFFF_FFFF, 8'h00,
                               1, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_READ, G_IRQ_ADDR, '0, 8'h00,
                               1, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        // Window of a channel that does not exist.
        directed.push_back(row(CMD_WRITE, chan_reg(MAX_CHANNELS, OFF_SCRATCH_ZERO), 32'hFFFF_FFFF,
                               8'h00, 1, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_READ, chan_reg(MAX_CHANNELS, OFF_SCRATCH_ZERO), '0, 8'h00,
                               1, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_WRITE, chan_reg(0, OFF_SCRATCH_TWENTY), 32'hFFFF_FFFF, 8'h00,
                               1, '0, EV_NONE, 2'd0, 8'h00, 1'b0));
        directed.push_back(row(CMD_READ, chan_reg(0, OFF_SCRATCH_TWENTY), '0, 8'h00,
                               1, 32'hFFFF_FFFF, EV_NONE, 2'd0, 8'h00, 1'b0));
        foreach (directed[i])
            send_access(directed[i].acc, directed[i].pinned, directed[i].res);

        // Random part, in phases with a fresh device configuration each.
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph)
                0: load_devices(7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00);
                // All slots share one address and channel: the lowest populated one wins.
                1: load_devices(7'h7F, 7'h7F, 7'h7F, 7'h02, 7'h02, 7'h02, 7'h07);
                2: load_devices(7'h7F, 7'h7F, 7'h7F, 7'h02, 7'h02, 7'h02, 7'h06);
                // Channel code three, written with all data bits set, matches no channel.
                3: load_devices(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                CFG_DATA_W'($urandom), 7'h7F, 7'h7F, 7'h7F, 7'h7F);
                default:
                begin
                    load_devices(CFG_DATA_W'($urandom),
                                 ($urandom_range(0, 1) != 0) ? slot_addr_m[0]
                                                             : CFG_DATA_W'($urandom),
                                 ($urandom_range(0, 1) != 0) ? slot_addr_m[0]
                                                             : CFG_DATA_W'($urandom),
                                 CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                         : $urandom_range(0, 2)),
                                 CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                         : $urandom_range(0, 2)),
                                 CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                         : $urandom_range(0, 2)),
                                 CFG_DATA_W'($urandom));
                end
            endcase
            src_gap_pct    = (ph % 3) * 15;
            sink_stall_pct = ((ph + 1) % 3) * 15;
            no_idle        = (ph == 7);
            target         = sent_count + 200;
            while (sent_count < target)
            begin
                if ($urandom_range(0, 99) < 65)
                    run_bus_sequence();
                else
                    send_loose_access();
            end
        end

        drain();
        repeat (5) @(posedge clk);
        if (error_count == 0)
            $display("[i2c_host_controller_regs] OK");
        else
            $display("[i2c_host_controller_regs] ERROR");
        $finish;
    end

endmodule
